FILE: src/tdss_pkg.sv
// tdss_pkg: types, codes and constants of the two door servo sequencer
// used by tdss_if, tdss_core, tdss_res_fifo and two_door_servo_sequencer
// depends on nothing
package tdss_pkg;

    localparam int TIME_BITS  = 32;
    localparam int PULSE_W    = 12;
    localparam int MS_W       = 16;
    localparam int APB_AW     = 5;
    localparam int APB_DW     = 32;
    localparam int RES_DEPTH  = 4;
    localparam int RES_PTR_W  = $clog2(RES_DEPTH);
    localparam int RES_CNT_W  = $clog2(RES_DEPTH + 1);

    typedef logic [2:0]         t_action;
    typedef logic [2:0]         t_mode;
    typedef logic [2:0]         t_reg_idx;
    typedef logic [PULSE_W-1:0] t_pulse;
    typedef logic [MS_W-1:0]    t_ms;
    typedef logic [TIME_BITS-1:0] t_time;

    // event codes
    localparam t_action ACT_TICK      = 3'd0;
    localparam t_action ACT_OPEN      = 3'd1;
    localparam t_action ACT_CLOSE     = 3'd2;
    localparam t_action ACT_REACHED   = 3'd3;
    localparam t_action ACT_OPEN_NOW  = 3'd4;
    localparam t_action ACT_CLOSE_NOW = 3'd5;

    // door modes
    localparam t_mode MODE_NONE   = 3'd0;
    localparam t_mode MODE_SINGLE = 3'd1;
    localparam t_mode MODE_SYNC   = 3'd2;
    localparam t_mode MODE_DELAY  = 3'd3;
    localparam t_mode MODE_SEQ    = 3'd4;

    // register indexes
    localparam t_reg_idx REG_PRE_MODE   = 3'd0;
    localparam t_reg_idx REG_POST_MODE  = 3'd1;
    localparam t_reg_idx REG_D0_OPEN    = 3'd2;
    localparam t_reg_idx REG_D1_OPEN    = 3'd3;
    localparam t_reg_idx REG_D0_CLOSE   = 3'd4;
    localparam t_reg_idx REG_D1_CLOSE   = 3'd5;
    localparam t_reg_idx REG_DELAY      = 3'd6;
    localparam t_reg_idx REG_SETTLE     = 3'd7;

    // reset values
    localparam t_pulse RST_PULSE  = 12'd1500;
    localparam t_ms    RST_DELAY  = 16'd500;
    localparam t_ms    RST_SETTLE = 16'd100;

    typedef enum logic [1:0] {
        SEQ_IDLE     = 2'd0,
        SEQ_OPENING  = 2'd1,
        SEQ_CLOSING  = 2'd2,
        SEQ_COMPLETE = 2'd3
    } t_seq_state;

    typedef enum logic [1:0] {
        DOOR_CLOSED  = 2'd0,
        DOOR_OPENING = 2'd1,
        DOOR_OPEN    = 2'd2,
        DOOR_CLOSING = 2'd3
    } t_door_state;

    typedef struct packed {
        t_mode  pre_deploy_mode;
        t_mode  post_deploy_mode;
        t_pulse door0_open_pulse;
        t_pulse door1_open_pulse;
        t_pulse door0_close_pulse;
        t_pulse door1_close_pulse;
        t_ms    second_door_delay;
        t_ms    settle_time;
    } t_cfg;

    typedef struct packed {
        logic        cmd_valid;
        logic        cmd_door;
        t_pulse      cmd_pulse;
        logic        last;
        t_seq_state  seq_status;
        t_door_state door_status;
    } t_result;

    // one or two result words from one accepted event
    typedef struct packed {
        logic    valid;
        logic    two;
        t_result r0;
        t_result r1;
    } t_push;

endpackage

FILE: src/tdss_if.sv
// tdss_if: valid/ready channels for event words and result words
// depends on tdss_pkg
interface tdss_evt_if
    import tdss_pkg::*;
;
    logic       valid;
    logic       ready;
    t_action    action;
    logic       deploying;
    logic [1:0] door_index;

    modport source (output valid, action, deploying, door_index, input ready);
    modport sink   (input valid, action, deploying, door_index, output ready);
endinterface

interface tdss_res_if
    import tdss_pkg::*;
;
    logic        valid;
    logic        ready;
    logic        cmd_valid;
    logic        cmd_door;
    t_pulse      cmd_pulse;
    logic        last;
    logic [1:0]  seq_status;
    logic [1:0]  door_status;

    modport source (output valid, cmd_valid, cmd_door, cmd_pulse, last, seq_status,
                    door_status, input ready);
    modport sink   (input valid, cmd_valid, cmd_door, cmd_pulse, last, seq_status,
                    door_status, output ready);
endinterface

FILE: src/two_door_servo_sequencer.sv
// two_door_servo_sequencer: top level with apb register file, core and result queue
// depends on tdss_pkg, tdss_if, tdss_core, tdss_res_fifo
//
// usage
//   i_evt carries event words (action, deploying, door_index); a word is taken at
//   a rising edge with valid and ready both high
//   o_res carries result words (cmd_valid, cmd_door, cmd_pulse, last, seq_status,
//   door_status); each event gives one or two words, last marks the final one
//   apb port writes the eight setup registers at byte address 4*index; pready is
//   tied high and reads return the stored value
// flow and throughput
//   the event is evaluated in the accept cycle and its words are registered in
//   the result queue, which offers them in order behind any older words
//   one event per cycle is taken while the queue has room for two words; an
//   event with two servo commands gives two output words, which the four word
//   queue holds; a run of such events fills it and i_evt.ready drops
// reset
//   synchronous, active low: registers return to their defaults, sequencer idle,
//   doors closed, millisecond counter zero, queue empty
// stalls
//   when the receiver holds ready low the queue fills and i_evt.ready drops once
//   fewer than two entries are free; nothing is lost or reordered
module two_door_servo_sequencer
    import tdss_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    // event and result channels
    tdss_evt_if.sink          i_evt,
    tdss_res_if.source        o_res
);

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     cfg_wr;
    logic     accept;
    logic     room;
    t_push    push;
    t_result  res;

    // register file: writes complete in the access phase
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pre_deploy_mode   <= MODE_NONE;
            r_cfg.post_deploy_mode  <= MODE_NONE;
            r_cfg.door0_open_pulse  <= RST_PULSE;
            r_cfg.door1_open_pulse  <= RST_PULSE;
            r_cfg.door0_close_pulse <= RST_PULSE;
            r_cfg.door1_close_pulse <= RST_PULSE;
            r_cfg.second_door_delay <= RST_DELAY;
            r_cfg.settle_time       <= RST_SETTLE;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_PRE_MODE:  r_cfg.pre_deploy_mode   <= pwdata[2:0];
                REG_POST_MODE: r_cfg.post_deploy_mode  <= pwdata[2:0];
                REG_D0_OPEN:   r_cfg.door0_open_pulse  <= pwdata[PULSE_W-1:0];
                REG_D1_OPEN:   r_cfg.door1_open_pulse  <= pwdata[PULSE_W-1:0];
                REG_D0_CLOSE:  r_cfg.door0_close_pulse <= pwdata[PULSE_W-1:0];
                REG_D1_CLOSE:  r_cfg.door1_close_pulse <= pwdata[PULSE_W-1:0];
                REG_DELAY:     r_cfg.second_door_delay <= pwdata[MS_W-1:0];
                REG_SETTLE:    r_cfg.settle_time       <= pwdata[MS_W-1:0];
                default:       r_cfg.settle_time       <= r_cfg.settle_time;
            endcase
        end
    end

    // read back, zero extended
    always_comb begin
        unique case (reg_idx)
            REG_PRE_MODE:  prdata = APB_DW'(r_cfg.pre_deploy_mode);
            REG_POST_MODE: prdata = APB_DW'(r_cfg.post_deploy_mode);
            REG_D0_OPEN:   prdata = APB_DW'(r_cfg.door0_open_pulse);
            REG_D1_OPEN:   prdata = APB_DW'(r_cfg.door1_open_pulse);
            REG_D0_CLOSE:  prdata = APB_DW'(r_cfg.door0_close_pulse);
            REG_D1_CLOSE:  prdata = APB_DW'(r_cfg.door1_close_pulse);
            REG_DELAY:     prdata = APB_DW'(r_cfg.second_door_delay);
            REG_SETTLE:    prdata = APB_DW'(r_cfg.settle_time);
            default:       prdata = '0;
        endcase
    end

    // input side: take an event word whenever two queue entries are free
    assign i_evt.ready = room;
    assign accept      = i_evt.valid && room;

    tdss_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_action     (i_evt.action),
        .i_deploying  (i_evt.deploying),
        .i_door_index (i_evt.door_index),
        .i_cfg        (r_cfg),
        .o_push       (push)
    );

    // output side: result words wait here while the receiver stalls
    tdss_res_fifo u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_res.valid),
        .o_data  (res),
        .i_ready (o_res.ready)
    );

    assign o_res.cmd_valid   = res.cmd_valid;
    assign o_res.cmd_door    = res.cmd_door;
    assign o_res.cmd_pulse   = res.cmd_pulse;
    assign o_res.last        = res.last;
    assign o_res.seq_status  = res.seq_status;
    assign o_res.door_status = res.door_status;

endmodule

FILE: src/tdss_core.sv
// tdss_core: sequencer state and single pass event evaluation
// builds one or two result words per accepted event; depends on tdss_pkg
module tdss_core
    import tdss_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  t_action    i_action,
    input  logic       i_deploying,
    input  logic [1:0] i_door_index,
    input  t_cfg       i_cfg,
    output t_push      o_push
);

    t_seq_state  r_seq, n_seq;
    t_door_state r_door, n_door;
    t_mode       r_mode, n_mode;
    logic        r_phase, n_phase;
    logic [1:0]  r_reached, n_reached;
    logic        r_closing, n_closing;
    t_time       r_time, n_time;
    t_time       r_phase_start, n_phase_start;
    t_time       r_settle_start, n_settle_start;
    t_pulse      r_second_pulse, n_second_pulse;

    logic   running, is_tick, is_start, is_reach, is_imm;
    logic   st_closing, imm_closing;
    t_mode  st_mode;
    t_pulse p0, p1;
    t_time  t_next, now_eff, settle_diff, phase_diff;
    logic   dly_fire, seq_fire, fire, ph_eff, all_ok, settle_done, chk;
    logic [1:0] rf_eff;

    logic [1:0] c_cnt;
    logic       c0_door, c1_door;
    t_pulse     c0_pulse, c1_pulse;

    function automatic logic all_reached(t_mode m, logic ph, logic [1:0] rf);
        logic res;
        res = 1'b1;
        unique case (m)
            MODE_SINGLE: res = rf[0];
            MODE_SYNC:   res = (rf == 2'b11);
            MODE_DELAY,
            MODE_SEQ:    res = ph && (rf == 2'b11);
            default:     res = 1'b1;
        endcase
        return res;
    endfunction

    // decode and timing decisions
    always_comb begin
        running     = (r_seq == SEQ_OPENING) || (r_seq == SEQ_CLOSING);
        is_tick     = (i_action == ACT_TICK);
        is_start    = (i_action == ACT_OPEN) || (i_action == ACT_CLOSE);
        st_closing  = (i_action == ACT_CLOSE);
        if (st_closing) begin
            st_mode = i_deploying ? i_cfg.post_deploy_mode : i_cfg.pre_deploy_mode;
        end else begin
            st_mode = i_deploying ? i_cfg.pre_deploy_mode : i_cfg.post_deploy_mode;
        end
        is_reach    = (i_action == ACT_REACHED) && !i_door_index[1] && running;
        imm_closing = (i_action == ACT_CLOSE_NOW);
        is_imm      = ((i_action == ACT_OPEN_NOW) || imm_closing)
                      && (i_cfg.pre_deploy_mode != MODE_NONE);
        p0 = st_closing ? i_cfg.door0_close_pulse : i_cfg.door0_open_pulse;
        p1 = st_closing ? i_cfg.door1_close_pulse : i_cfg.door1_open_pulse;

        t_next     = r_time + TIME_BITS'(1);
        phase_diff = t_next - r_phase_start;
        dly_fire   = is_tick && running && (r_mode == MODE_DELAY) && !r_phase
                     && (phase_diff >= TIME_BITS'(i_cfg.second_door_delay));
        seq_fire   = is_reach && (r_mode == MODE_SEQ) && !r_phase
                     && (i_door_index[0] == r_closing);
        fire       = dly_fire || seq_fire;
        ph_eff     = r_phase || fire;
        rf_eff     = is_reach ? (r_reached | (2'b01 << i_door_index[0])) : r_reached;
        all_ok     = all_reached(r_mode, ph_eff, rf_eff);
        now_eff    = is_tick ? t_next : r_time;
        // settle window restarts at the moment the second door is commanded
        settle_diff = fire ? '0 : (now_eff - r_settle_start);
        settle_done = all_ok && (settle_diff >= TIME_BITS'(i_cfg.settle_time));
        chk         = running && (is_tick || is_reach);
    end

    // next state
    always_comb begin
        n_seq          = r_seq;
        n_door         = r_door;
        n_mode         = r_mode;
        n_phase        = r_phase;
        n_reached      = r_reached;
        n_closing      = r_closing;
        n_time         = r_time;
        n_phase_start  = r_phase_start;
        n_settle_start = r_settle_start;
        n_second_pulse = r_second_pulse;
        if (i_accept) begin
            if (is_tick) begin
                n_time = t_next;
            end
            if (chk) begin
                if (is_reach) begin
                    n_reached = rf_eff;
                end
                if (fire) begin
                    n_phase = 1'b1;
                end
                if (fire || !all_ok) begin
                    n_settle_start = now_eff;
                end
                if (settle_done) begin
                    n_seq  = SEQ_COMPLETE;
                    n_door = r_closing ? DOOR_CLOSED : DOOR_OPEN;
                end
            end
            if (is_start) begin
                n_mode = st_mode;
                if (st_mode == MODE_NONE) begin
                    n_seq = SEQ_COMPLETE;
                end else begin
                    n_seq          = st_closing ? SEQ_CLOSING : SEQ_OPENING;
                    n_door         = st_closing ? DOOR_CLOSING : DOOR_OPENING;
                    n_phase        = 1'b0;
                    n_phase_start  = r_time;
                    n_settle_start = r_time;
                    n_reached      = 2'b00;
                    n_closing      = st_closing;
                    n_second_pulse = st_closing ? p0 : p1;
                end
            end
            if (is_imm) begin
                n_door = imm_closing ? DOOR_CLOSED : DOOR_OPEN;
            end
        end
    end

    // servo commands and result words
    always_comb begin
        c_cnt    = 2'd0;
        c0_door  = 1'b0;
        c0_pulse = '0;
        c1_door  = 1'b0;
        c1_pulse = '0;
        if (is_start) begin
            unique case (st_mode)
                MODE_SINGLE: begin
                    c_cnt    = 2'd1;
                    c0_pulse = p0;
                end
                MODE_SYNC: begin
                    c_cnt    = 2'd2;
                    c0_pulse = p0;
                    c1_door  = 1'b1;
                    c1_pulse = p1;
                end
                MODE_DELAY,
                MODE_SEQ: begin
                    c_cnt    = 2'd1;
                    c0_door  = st_closing;
                    c0_pulse = st_closing ? p1 : p0;
                end
                default: c_cnt = 2'd0;
            endcase
        end else if (fire) begin
            c_cnt    = 2'd1;
            c0_door  = !r_closing;
            c0_pulse = r_second_pulse;
        end else if (is_imm) begin
            c_cnt    = (i_cfg.pre_deploy_mode >= MODE_SYNC) ? 2'd2 : 2'd1;
            c0_pulse = imm_closing ? i_cfg.door0_close_pulse : i_cfg.door0_open_pulse;
            c1_door  = 1'b1;
            c1_pulse = imm_closing ? i_cfg.door1_close_pulse : i_cfg.door1_open_pulse;
        end

        o_push.valid          = i_accept;
        o_push.two            = (c_cnt == 2'd2);
        o_push.r0.cmd_valid   = (c_cnt != 2'd0);
        o_push.r0.cmd_door    = c0_door;
        o_push.r0.cmd_pulse   = c0_pulse;
        o_push.r0.last        = (c_cnt != 2'd2);
        o_push.r0.seq_status  = n_seq;
        o_push.r0.door_status = n_door;
        o_push.r1.cmd_valid   = 1'b1;
        o_push.r1.cmd_door    = c1_door;
        o_push.r1.cmd_pulse   = c1_pulse;
        o_push.r1.last        = 1'b1;
        o_push.r1.seq_status  = n_seq;
        o_push.r1.door_status = n_door;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq          <= SEQ_IDLE;
            r_door         <= DOOR_CLOSED;
            r_mode         <= MODE_NONE;
            r_phase        <= 1'b0;
            r_reached      <= 2'b00;
            r_closing      <= 1'b0;
            r_time         <= '0;
            r_phase_start  <= '0;
            r_settle_start <= '0;
            r_second_pulse <= '0;
        end else begin
            r_seq          <= n_seq;
            r_door         <= n_door;
            r_mode         <= n_mode;
            r_phase        <= n_phase;
            r_reached      <= n_reached;
            r_closing      <= n_closing;
            r_time         <= n_time;
            r_phase_start  <= n_phase_start;
            r_settle_start <= n_settle_start;
            r_second_pulse <= n_second_pulse;
        end
    end

    // time only moves on a tick
    a_time_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_accept && is_tick) |=> $stable(r_time))
        else $error("millisecond counter moved without a tick");

    // a start in mode none completes at once
    a_none_completes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && is_start && (st_mode == MODE_NONE)) |=> (r_seq == SEQ_COMPLETE))
        else $error("start in mode none did not complete");

    // the deferred door is commanded at most once per sequence
    a_single_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && fire) |=> r_phase)
        else $error("second door command without phase change");

endmodule

FILE: src/tdss_res_fifo.sv
// tdss_res_fifo: small result word queue between the core and the output channel
// takes one or two words per push; depends on tdss_pkg
module tdss_res_fifo
    import tdss_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    output logic    o_room,
    output logic    o_valid,
    output t_result o_data,
    input  logic    i_ready
);

    t_result r_mem [RES_DEPTH];
    logic [RES_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [RES_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [RES_CNT_W-1:0] r_count, n_count;
    logic pop;
    logic [RES_PTR_W-1:0] wr_ptr1;

    assign o_room  = (r_count <= RES_CNT_W'(RES_DEPTH - 2));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign pop     = o_valid && i_ready;
    assign wr_ptr1 = r_wr_ptr + RES_PTR_W'(1);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push.valid) begin
            n_wr_ptr = i_push.two ? (r_wr_ptr + RES_PTR_W'(2)) : wr_ptr1;
            n_count  = r_count + (i_push.two ? RES_CNT_W'(2) : RES_CNT_W'(1));
        end
        if (pop) begin
            n_rd_ptr = r_rd_ptr + RES_PTR_W'(1);
            n_count  = n_count - RES_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.r0;
            if (i_push.two) begin
                r_mem[wr_ptr1] <= i_push.r1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.valid |-> o_room)
        else $error("result queue pushed without room for two words");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= RES_CNT_W'(RES_DEPTH))
        else $error("result queue count out of range");

endmodule

FILE: tb/tb_top.sv
// tb_top: self-checking bench for the two door servo sequencer, event and result words
// checked against a behavioral model of the sequencer kept inside this module
// depends on tdss_pkg, tdss_if and two_door_servo_sequencer
module tb_top
    import tdss_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // event codes the block ignores
    localparam t_action ACT_SPARE_LO = 3'd6;
    localparam t_action ACT_SPARE_HI = 3'd7;
    // mode codes outside the named set; on a start the block commands no door for them
    localparam t_mode MODE_RSVD_LO = 3'd5;
    localparam t_mode MODE_RSVD_HI = 3'd7;

    localparam int RAND_PHASES    = 8;
    localparam int EVENTS_PER_SET = 100;
    // longest quiet stretch of a good run is a sender gap plus a drain and a
    // receiver stall; this limit is far beyond that
    localparam int WATCHDOG_LIMIT = 3000;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    tdss_evt_if evt ();
    tdss_res_if res ();

    two_door_servo_sequencer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_evt   (evt),
        .o_res   (res)
    );

    // ---------------------------------------------------------------------
    // directed table: a row is either a register write or an event word;
    // typed rows carry the one no-command word the event must give
    // ---------------------------------------------------------------------
    typedef struct packed {
        logic        is_cfg;
        t_reg_idx    reg_idx;
        logic [15:0] value;
        t_action     action;
        logic        dep;
        logic [1:0]  idx;
        logic        typed;
        t_seq_state  exp_seq;
        t_door_state exp_door;
    } t_step;

    localparam int N_DIRECTED = 41;
    localparam t_step DIRECTED [N_DIRECTED] = '{
        // reset setup, both modes none: nothing moves
        '{1'b0, REG_PRE_MODE, 16'd0, ACT_TICK,      1'b0, 2'd0, 1'b1, SEQ_IDLE, DOOR_CLOSED},
        '{1'b0, REG_PRE_MODE, 16'd0, ACT_OPEN_NOW,  1'b1, 2'd0, 1'b1, SEQ_IDLE, DOOR_CLOSED},
        '{1'b0, REG_PRE_MODE, 16'd0, ACT_REACHED,   1'b0, 2'd0, 1'b1, SEQ_IDLE, DOOR_CLOSED},
        '{1'b0, REG_PRE_MODE, 16'd0, ACT_SPARE_HI,  1'b1, 2'd3, 1'b1, SEQ_IDLE, DOOR_CLOSED},
        '{1'b0, REG_PRE_MODE, 16'd0, ACT_OPEN,      1'b0, 2'd0, 1'b1, SEQ_COMPLETE,
          DOOR_CLOSED},
        // dual sync before deploy, single after, pulse extremes, no waits
        '{1'b1, REG_PRE_MODE,  16'(MODE_SYNC),   ACT_TICK, 1'b0, 2'd0, 1'b0, SEQ_IDLE,
          DOOR_CLOSED},
        '{1'b1, REG_POST_MODE, 16'(MODE_SINGLE), ACT_TICK, 1'b0, 2'd0, 1'b0, SEQ_IDLE,
          DOOR_CLOSED},
        '{1'b1, REG_D0_OPEN,  16'd4095, ACT_TICK, 1'b0, 2'd0, 1'b0, SEQ_IDLE, DOOR_CLOSED},
        '{1'b1, REG_D1_OPEN,  16'd0,    ACT_TICK, 1'b0, 2'd0, 1'b0, SEQ_IDLE, DOOR_CLOSED},
        '{1'b1, REG_D0_CLOSE, 16'd0,    ACT_TICK, 1'b0, 2'd0, 1'b0, SEQ_IDLE, DOOR_CLOSED},
        '{1'b1, REG_D1_CLOSE, 16'd4095, ACT_TICK, 1'b0, 2'd0, 1'b0, SEQ_IDLE, DOOR_CLOSED},
        '{1'b1, REG_DELAY,    16'd0,    ACT_TICK, 1'b0, 2'd0, 1'b0, SEQ_IDLE, DOOR_CLOSED},
        '{1'b1, REG_SETTLE,   16'd0,    ACT_TICK, 1'b0, 2'd0, 1'b0, SEQ_IDLE, DOOR_CLOSED},
        '{1'b0, REG_PRE_MODE, 16'd0, ACT_OPEN_NOW,  1'b0, 2'd0, 1'b0, SEQ_IDLE, DOOR_CLOSED},
        '{1'b0, REG_PRE_MODE, 16'd0, ACT_CLOSE_NOW, 1'b0, 2'd0, 1'b0, SEQ_IDLE, DOOR_CLOSED},
        '{1'b0, REG_PRE_MODE, 16'd0, ACT_OPEN,      1'b1, 2'd0, 1'b0, SEQ_IDLE, DOOR_CLOSED},
        // reports for doors that do not exist are dropped
        '{1'b0, REG_PRE_MODE, 16'd0, ACT_REACHED,   1'b0, 2'd2, 1'b1, SEQ_OPENING,
          DOOR_OPENING},
        '{1'b0, REG_PRE_MODE, 16'd0, ACT_REACHED,   1'b0, 2'd3, 1'b1, SEQ_OPENING,
          DOOR_OPENING},
        '{1'b0, REG_PRE_MODE, 16'd0, ACT_REACHED,   1'b0, 2'd0, 1'b0, SEQ_IDLE, DOOR_CLOSED},
        '{1'b0, REG_PRE_MODE, 16'd0, ACT_REACHED,   1'b0, 2'd1, 1'b0, SEQ_IDLE, DOOR_CLOSED},
        '{1'b0, REG_PRE_MODE, 16'd0, ACT_CLOSE,     1'b1, 2'd0, 1'b0, SEQ_IDLE, DOOR_CLOSED},
        '{1'b0, REG_PRE_MODE, 16'd0, ACT_REACHED,   1'b0, 2'd0, 1'b0, SEQ_IDLE, DOOR_CLOSED},
        // second door after a delay
        '{1'b1, REG_PRE_MODE, 16'(MODE_DELAY), ACT_TICK, 1'b0, 2'd0, 1'b0, SEQ_IDLE,
          DOOR_CLOSED},
        '{1'b1, REG_DELAY,  16'd2, ACT_TICK, 1'b0, 2'd0, 1'b0, SEQ_IDLE, DOOR_CLOSED},
        '{1'b1, REG_SETTLE, 16'd1, ACT_TICK, 1'b0, 2'd0, 1'b0, SEQ_IDLE, DOOR_CLOSED},
        '{1'b0, REG_PRE_MODE, 16'd0, ACT_OPEN,      1'b1, 2'd0, 1'b0, SEQ_IDLE, DOOR_CLOSED},
        '{1'b0, REG_PRE_MODE, 16'd0, ACT_TICK,      1'b0, 2'd0, 1'b0, SEQ_IDLE, DOOR_CLOSED},
        '{1'b0, REG_PRE_MODE, 16'd0, ACT_TICK,      1'b0, 2'd0, 1'b0, SEQ_IDLE, DOOR_CLOSED},
        '{1'b0, REG_PRE_MODE, 16'd0, ACT_REACHED,   1'b0, 2'd0, 1'b0, SEQ_IDLE, DOOR_CLOSED},
        '{1'b0, REG_PRE_MODE, 16'd0, ACT_REACHED,   1'b0, 2'd1, 1'b0, SEQ_IDLE, DOOR_CLOSED},
        '{1'b0, REG_PRE_MODE, 16'd0, ACT_TICK,      1'b0, 2'd0, 1'b0, SEQ_IDLE, DOOR_CLOSED},
        // second door on the first door's report, closing starts with door 1
        '{1'b1, REG_POST_MODE, 16'(MODE_SEQ), ACT_TICK, 1'b0, 2'd0, 1'b0, SEQ_IDLE,
          DOOR_CLOSED},
        '{1'b0, REG_PRE_MODE, 16'd0, ACT_CLOSE,     1'b1, 2'd0, 1'b0, SEQ_IDLE, DOOR_CLOSED},
        '{1'b0, REG_PRE_MODE, 16'd0, ACT_REACHED,   1'b0, 2'd0, 1'b0, SEQ_IDLE, DOOR_CLOSED},
        '{1'b0, REG_PRE_MODE, 16'd0, ACT_REACHED,   1'b0, 2'd1, 1'b0, SEQ_IDLE, DOOR_CLOSED},
        '{1'b0, REG_PRE_MODE, 16'd0, ACT_TICK,      1'b0, 2'd0, 1'b0, SEQ_IDLE, DOOR_CLOSED},
        // undefined mode and longest waits: runs without commands, never settles here
        '{1'b1, REG_PRE_MODE, 16'(MODE_RSVD_HI), ACT_TICK, 1'b0, 2'd0, 1'b0, SEQ_IDLE,
          DOOR_CLOSED},
        '{1'b1, REG_SETTLE, 16'd65535, ACT_TICK, 1'b0, 2'd0, 1'b0, SEQ_IDLE, DOOR_CLOSED},
        '{1'b1, REG_DELAY,  16'd65535, ACT_TICK, 1'b0, 2'd0, 1'b0, SEQ_IDLE, DOOR_CLOSED},
        '{1'b0, REG_PRE_MODE, 16'd0, ACT_OPEN,      1'b1, 2'd0, 1'b0, SEQ_IDLE, DOOR_CLOSED},
        '{1'b0, REG_PRE_MODE, 16'd0, ACT_SPARE_LO,  1'b0, 2'd2, 1'b1, SEQ_OPENING,
          DOOR_OPENING}
    };

    // ---------------------------------------------------------------------
    // sequencer model: setup registers and state as the block holds them
    // ---------------------------------------------------------------------
    t_cfg        setup;
    t_seq_state  sq_state;
    t_door_state dr_state;
    t_mode       run_mode;
    logic        second_sent;
    logic [1:0]  at_target;
    logic        dir_close;
    t_time       ms_now;
    t_time       phase_t0;
    t_time       settle_t0;
    t_pulse      deferred_pulse;

    // servo commands raised by the current event
    int          cmd_n;
    logic        cmd_door_q [2];
    t_pulse      cmd_pulse_q [2];
    // result words of the current event
    int          step_count;
    t_result     step_words [2];

    // result words still owed by the block, oldest first
    t_result     pending_words [$];

    int err_count     = 0;
    int events_sent   = 0;
    int table_events  = 0;
    int words_checked = 0;
    int reg_writes    = 0;
    int burst_left    = 0;
    int stall_clock   = 0;
    int stall_style   = 0;

    function automatic void reset_model();
        setup = '{MODE_NONE, MODE_NONE, RST_PULSE, RST_PULSE, RST_PULSE, RST_PULSE,
                  RST_DELAY, RST_SETTLE};
        sq_state       = SEQ_IDLE;
        dr_state       = DOOR_CLOSED;
        run_mode       = MODE_NONE;
        second_sent    = 1'b0;
        at_target      = 2'b00;
        dir_close      = 1'b0;
        ms_now         = '0;
        phase_t0       = '0;
        settle_t0      = '0;
        deferred_pulse = '0;
    endfunction

    function automatic void servo_cmd(logic door, t_pulse pulse);
        if (cmd_n < 2) begin
            cmd_door_q[cmd_n]  = door;
            cmd_pulse_q[cmd_n] = pulse;
            cmd_n++;
        end
    endfunction

    function automatic bit in_motion();
        return sq_state == SEQ_OPENING || sq_state == SEQ_CLOSING;
    endfunction

    // true once every door the running mode moves has reported
    function automatic bit doors_home();
        case (run_mode)
            MODE_SINGLE:          return at_target[0];
            MODE_SYNC:            return &at_target;
            MODE_DELAY, MODE_SEQ: return second_sent && (&at_target);
            default:              return 1'b1;
        endcase
    endfunction

    function automatic void settle_check();
        if (!doors_home()) begin
            settle_t0 = ms_now;
        end else if (t_time'(ms_now - settle_t0) >= t_time'(setup.settle_time)) begin
            sq_state = SEQ_COMPLETE;
            dr_state = dir_close ? DOOR_CLOSED : DOOR_OPEN;
        end
    endfunction

    function automatic void begin_motion(logic closing, t_mode mode);
        t_pulse p0;
        t_pulse p1;
        p0 = closing ? setup.door0_close_pulse : setup.door0_open_pulse;
        p1 = closing ? setup.door1_close_pulse : setup.door1_open_pulse;
        run_mode = mode;
        if (mode == MODE_NONE) begin
            sq_state = SEQ_COMPLETE;
            return;
        end
        sq_state       = closing ? SEQ_CLOSING : SEQ_OPENING;
        dr_state       = closing ? DOOR_CLOSING : DOOR_OPENING;
        second_sent    = 1'b0;
        phase_t0       = ms_now;
        settle_t0      = ms_now;
        at_target      = 2'b00;
        dir_close      = closing;
        // the door moved second is door 1 when opening, door 0 when closing
        deferred_pulse = closing ? p0 : p1;
        case (mode)
            MODE_SINGLE: servo_cmd(1'b0, p0);
            MODE_SYNC: begin
                servo_cmd(1'b0, p0);
                servo_cmd(1'b1, p1);
            end
            MODE_DELAY, MODE_SEQ: begin
                if (closing) servo_cmd(1'b1, p1);
                else servo_cmd(1'b0, p0);
            end
            default: ;
        endcase
    endfunction

    function automatic void snap_doors(logic closing);
        if (setup.pre_deploy_mode == MODE_NONE) return;
        servo_cmd(1'b0, closing ? setup.door0_close_pulse : setup.door0_open_pulse);
        if (setup.pre_deploy_mode >= MODE_SYNC)
            servo_cmd(1'b1, closing ? setup.door1_close_pulse : setup.door1_open_pulse);
        dr_state = closing ? DOOR_CLOSED : DOOR_OPEN;
    endfunction

    // one event through the model, leaves its result words in step_words
    function automatic void door_seq_step(t_action act, logic dep, logic [1:0] idx);
        cmd_n = 0;
        case (act)
            ACT_TICK: begin
                ms_now = ms_now + t_time'(1);
                if (in_motion()) begin
                    if (run_mode == MODE_DELAY && !second_sent &&
                        t_time'(ms_now - phase_t0) >= t_time'(setup.second_door_delay)) begin
                        servo_cmd(!dir_close, deferred_pulse);
                        second_sent = 1'b1;
                        settle_t0   = ms_now;
                    end
                    settle_check();
                end
            end
            ACT_OPEN:
                begin_motion(1'b0, dep ? setup.pre_deploy_mode : setup.post_deploy_mode);
            ACT_CLOSE:
                begin_motion(1'b1, dep ? setup.post_deploy_mode : setup.pre_deploy_mode);
            ACT_REACHED: begin
                if (idx < 2 && in_motion()) begin
                    at_target[idx[0]] = 1'b1;
                    // first door home starts the second one in sequential mode
                    if (run_mode == MODE_SEQ && !second_sent && idx[0] == dir_close) begin
                        servo_cmd(!dir_close, deferred_pulse);
                        second_sent = 1'b1;
                        settle_t0   = ms_now;
                    end
                    settle_check();
                end
            end
            ACT_OPEN_NOW:  snap_doors(1'b0);
            ACT_CLOSE_NOW: snap_doors(1'b1);
            default: ;
        endcase
        step_count = (cmd_n == 0) ? 1 : cmd_n;
        for (int k = 0; k < step_count; k++) begin
            step_words[k].cmd_valid   = (cmd_n != 0);
            step_words[k].cmd_door    = (cmd_n != 0) ? cmd_door_q[k] : 1'b0;
            step_words[k].cmd_pulse   = (cmd_n != 0) ? cmd_pulse_q[k] : '0;
            step_words[k].last        = (k == step_count - 1);
            step_words[k].seq_status  = sq_state;
            step_words[k].door_status = dr_state;
        end
    endfunction

    // ---------------------------------------------------------------------
    // clock, reset and start values
    // ---------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        evt.valid      = 1'b0;
        evt.action     = ACT_TICK;
        evt.deploying  = 1'b0;
        evt.door_index = 2'd0;
        res.ready      = 1'b0;
    end

    // ---------------------------------------------------------------------
    // event driver
    // ---------------------------------------------------------------------

    // offer one event word, wait for the block to take it, then book the
    // words it owes; bursts of back to back words alternate with gaps
    task automatic send_word(t_action act, logic dep, logic [1:0] idx,
                             logic typed = 1'b0, t_seq_state exp_seq = SEQ_IDLE,
                             t_door_state exp_door = DOOR_CLOSED);
        t_result typed_word;
        evt.valid      <= 1'b1;
        evt.action     <= act;
        evt.deploying  <= dep;
        evt.door_index <= idx;
        do @(posedge i_clk); while (!evt.ready);
        door_seq_step(act, dep, idx);
        if (typed) begin
            // a typed row always gives one word with no servo command
            typed_word             = '0;
            typed_word.last        = 1'b1;
            typed_word.seq_status  = exp_seq;
            typed_word.door_status = exp_door;
            pending_words.push_back(typed_word);
        end else begin
            for (int k = 0; k < step_count; k++) pending_words.push_back(step_words[k]);
        end
        if (act <= ACT_CLOSE_NOW) events_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            evt.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(0, 30);
        end
    endtask

    // hold off new events until every owed word is out, plus the latency
    // of the result queue so nothing is still in flight
    task automatic wait_idle();
        evt.valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // apb write: setup cycle, access cycle, register taken with pready high
    task automatic write_reg(t_reg_idx r, logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        case (r)
            REG_PRE_MODE:  setup.pre_deploy_mode   = v[2:0];
            REG_POST_MODE: setup.post_deploy_mode  = v[2:0];
            REG_D0_OPEN:   setup.door0_open_pulse  = v[PULSE_W-1:0];
            REG_D1_OPEN:   setup.door1_open_pulse  = v[PULSE_W-1:0];
            REG_D0_CLOSE:  setup.door0_close_pulse = v[PULSE_W-1:0];
            REG_D1_CLOSE:  setup.door1_close_pulse = v[PULSE_W-1:0];
            REG_DELAY:     setup.second_door_delay = v[MS_W-1:0];
            REG_SETTLE:    setup.settle_time       = v[MS_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // new random setup: mostly named modes, short waits, now and then the extremes
    task automatic write_random_setup();
        logic [31:0] v;
        for (int r = REG_PRE_MODE; r <= REG_SETTLE; r++) begin
            case (t_reg_idx'(r))
                REG_PRE_MODE, REG_POST_MODE:
                    v = ($urandom_range(0, 9) == 0) ?
                        $urandom_range(MODE_RSVD_LO, MODE_RSVD_HI) :
                        $urandom_range(MODE_NONE, MODE_SEQ);
                REG_DELAY, REG_SETTLE:
                    v = ($urandom_range(0, 24) == 0) ? 32'hFFFF : $urandom_range(0, 6);
                default: begin
                    case ($urandom_range(0, 5))
                        0:       v = 32'd0;
                        1:       v = 32'hFFF;
                        default: v = $urandom_range(0, 4095);
                    endcase
                end
            endcase
            write_reg(t_reg_idx'(r), v);
        end
    endtask

    // anything at all: ignored codes, phantom doors, immediate moves
    task automatic send_noise();
        send_word(t_action'($urandom_range(ACT_TICK, ACT_SPARE_HI)),
                  1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
    endtask

    // a start followed by ticks and door reports, with some noise mixed in
    task automatic run_motion();
        int steps;
        int pick;
        steps = $urandom_range(2, 14);
        send_word($urandom_range(0, 1) ? ACT_CLOSE : ACT_OPEN,
                  1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
        repeat (steps) begin
            pick = $urandom_range(0, 9);
            if (pick < 5) send_word(ACT_TICK, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
            else if (pick < 9) send_word(ACT_REACHED, 1'($urandom_range(0, 1)),
                                         2'($urandom_range(0, 1)));
            else send_noise();
        end
    endtask

    // ---------------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------------
    initial begin
        int target;
        reset_model();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].is_cfg) begin
                wait_idle();
                write_reg(DIRECTED[i].reg_idx, 32'(DIRECTED[i].value));
            end else begin
                send_word(DIRECTED[i].action, DIRECTED[i].dep, DIRECTED[i].idx,
                          DIRECTED[i].typed, DIRECTED[i].exp_seq, DIRECTED[i].exp_door);
                table_events++;
            end
        end

        // random part, one setup per phase
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wait_idle();
            write_random_setup();
            target = events_sent + EVENTS_PER_SET;
            while (events_sent < target) begin
                if ($urandom_range(0, 9) < 8) run_motion();
                else repeat ($urandom_range(1, 4)) send_noise();
                // now and then let the block run completely dry
                if ($urandom_range(0, 11) == 0) wait_idle();
            end
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        $display("covered %0d events (%0d from the table) over %0d random setups",
                 events_sent, table_events, RAND_PHASES);
        $display("%0d result words checked, %0d register writes, %0d mismatches",
                 words_checked, reg_writes, err_count);
        if (err_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // ---------------------------------------------------------------------
    // result side: stall pattern and checker
    // ---------------------------------------------------------------------

    // the stall style is redrawn whenever the low seven bits of stall_clock wrap:
    // streaming, light random, fixed duty and heavy backpressure
    always @(posedge i_clk) begin
        stall_clock <= stall_clock + 1;
        if (stall_clock[6:0] == 7'd0) stall_style <= $urandom_range(0, 3);
        case (stall_style)
            0:       res.ready <= 1'b1;
            1:       res.ready <= ($urandom_range(0, 3) != 0);
            2:       res.ready <= (stall_clock[3:0] < 4'd5);
            default: res.ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && res.valid && res.ready) begin
            if (pending_words.size() == 0) begin
                $error("result word with nothing expected");
                err_count++;
            end else begin
                want = pending_words.pop_front();
                words_checked++;
                check_field("cmd_valid",   16'(want.cmd_valid),   16'(res.cmd_valid));
                check_field("cmd_door",    16'(want.cmd_door),    16'(res.cmd_door));
                check_field("cmd_pulse",   16'(want.cmd_pulse),   16'(res.cmd_pulse));
                check_field("last",        16'(want.last),        16'(res.last));
                check_field("seq_status",  16'(want.seq_status),  16'(res.seq_status));
                check_field("door_status", 16'(want.door_status), 16'(res.door_status));
            end
        end
    end

    // watchdog: too many cycles in a row with no word or register moving
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((evt.valid && evt.ready) || (res.valid && res.ready) || psel) quiet = 0;
            else quiet++;
        end
        $display("timeout after %0d quiet cycles, %0d words still owed",
                 quiet, pending_words.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
